FILE: rtl/idbt_pkg.sv
`timescale 1ns / 1ps

package idbt_pkg;

	localparam int BOOKED_DEPTH = 64;
	localparam int DOUBLE_DEPTH = 256;
	localparam int TIME_WIDTH   = 32;

	localparam int BCNT_W  = $clog2(BOOKED_DEPTH + 1);
	localparam int DCNT_W  = $clog2(DOUBLE_DEPTH + 1);
	localparam int BADDR_W = (BOOKED_DEPTH > 1) ? $clog2(BOOKED_DEPTH) : 1;
	localparam int DADDR_W = (DOUBLE_DEPTH > 1) ? $clog2(DOUBLE_DEPTH) : 1;
	localparam int IDX_W   = (DCNT_W > BCNT_W) ? DCNT_W : BCNT_W;
	localparam int SUM_W   = IDX_W + 1;

	localparam int STATUS_W = 2;
	localparam int NDR_W    = 7;

	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [TIME_WIDTH-1:0] time_t;

	localparam status_t STAT_ADMIT   = 2'd0;
	localparam status_t STAT_TRIPLE  = 2'd1;
	localparam status_t STAT_FULL    = 2'd2;
	localparam status_t STAT_INVALID = 2'd3;

endpackage

FILE: rtl/idbt_ram.sv
`timescale 1ns / 1ps

module idbt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/interval_double_booking_table.sv
// Admits half-open intervals [interval_start, interval_end) unless one would
// leave some instant booked three times. Status 0 admits, 1 refuses a triple
// booking, 2 refuses because the admitted table or the double table would
// overflow, 3 refuses an empty or reversed interval; only an admission changes
// the tables. One request is handled at a time: a valid request scans the
// stored double regions and then the admitted intervals through the single
// read port of each table memory, which the scan walks one entry per cycle.
// An invalid request skips both scans. The result sits in an output register,
// so the next request is taken while it waits.
`timescale 1ns / 1ps

module interval_double_booking_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [31:0]                interval_start,
	input  logic [31:0]                interval_end,
	output logic                       out_valid,
	input  logic                       out_stall,
	output idbt_pkg::status_t          status,
	output logic [idbt_pkg::NDR_W-1:0] new_double_regions
);

	import idbt_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_DSCAN = 2'd1;
	localparam logic [1:0] S_BSCAN = 2'd2;
	localparam logic [1:0] S_RESP  = 2'd3;

	logic [1:0]        state_q;
	logic [BCNT_W-1:0] bcount_q;
	logic [DCNT_W-1:0] dcount_q;
	logic [DCNT_W-1:0] dwr_q;
	logic [BCNT_W-1:0] added_q;
	logic [IDX_W-1:0]  scan_idx_q;
	logic              rvld_s1;
	status_t           res_q;
	logic              out_valid_q;
	time_t             s_q;
	time_t             e_q;
	status_t           status_q;
	logic [NDR_W-1:0]  ndr_q;

	time_t                 s_in;
	time_t                 e_in;
	logic [IDX_W-1:0]      lim;
	logic                  issue;
	logic [2*TIME_WIDTH-1:0] d_rdata;
	logic [2*TIME_WIDTH-1:0] b_rdata;
	time_t                 d_rs, d_re, b_rs, b_re;
	logic                  d_hit, b_hit;
	logic                  d_we;
	logic [2*TIME_WIDTH-1:0] d_wdata;
	logic                  b_we;
	logic                  full;
	status_t               final_stat;
	logic                  load_out;
	logic                  in_acc;

	assign s_in   = TIME_WIDTH'(interval_start);
	assign e_in   = TIME_WIDTH'(interval_end);
	assign in_acc = in_valid && !in_stall;

	always_comb begin
		lim   = (state_q == S_DSCAN) ? IDX_W'(dcount_q) : IDX_W'(bcount_q);
		issue = ((state_q == S_DSCAN) || (state_q == S_BSCAN)) && (scan_idx_q < lim);
		d_rs  = d_rdata[2*TIME_WIDTH-1:TIME_WIDTH];
		d_re  = d_rdata[TIME_WIDTH-1:0];
		b_rs  = b_rdata[2*TIME_WIDTH-1:TIME_WIDTH];
		b_re  = b_rdata[TIME_WIDTH-1:0];
		d_hit = rvld_s1 && (d_rs < e_q) && (s_q < d_re);
		b_hit = rvld_s1 && (b_rs < e_q) && (s_q < b_re);
		// intersections go past the committed count; they count only on admission
		d_we    = (state_q == S_BSCAN) && b_hit && (dwr_q < DCNT_W'(DOUBLE_DEPTH));
		d_wdata = {((b_rs > s_q) ? b_rs : s_q), ((b_re < e_q) ? b_re : e_q)};
		full    = (bcount_q >= BCNT_W'(BOOKED_DEPTH)) ||
			((SUM_W'(dcount_q) + SUM_W'(added_q)) > SUM_W'(DOUBLE_DEPTH));
		final_stat = ((res_q == STAT_ADMIT) && full) ? STAT_FULL : res_q;
		load_out   = (state_q == S_RESP) && (!out_valid_q || !out_stall);
		b_we       = load_out && (final_stat == STAT_ADMIT);
	end

	idbt_ram #(
		.WIDTH (2*TIME_WIDTH),
		.DEPTH (DOUBLE_DEPTH)
	) u_double_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (dwr_q[DADDR_W-1:0]),
		.wdata (d_wdata),
		.raddr (scan_idx_q[DADDR_W-1:0]),
		.rdata (d_rdata)
	);

	idbt_ram #(
		.WIDTH (2*TIME_WIDTH),
		.DEPTH (BOOKED_DEPTH)
	) u_booked_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (bcount_q[BADDR_W-1:0]),
		.wdata ({s_q, e_q}),
		.raddr (scan_idx_q[BADDR_W-1:0]),
		.rdata (b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bcount_q    <= '0;
			dcount_q    <= '0;
			dwr_q       <= '0;
			added_q     <= '0;
			scan_idx_q  <= '0;
			rvld_s1     <= 1'b0;
			res_q       <= STAT_ADMIT;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						scan_idx_q <= '0;
						rvld_s1    <= 1'b0;
						added_q    <= '0;
						dwr_q      <= dcount_q;
						if (s_in >= e_in) begin
							res_q   <= STAT_INVALID;
							state_q <= S_RESP;
						end else begin
							res_q   <= STAT_ADMIT;
							state_q <= S_DSCAN;
						end
					end
				end
				S_DSCAN: begin
					rvld_s1 <= issue && !d_hit;
					if (issue) begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
					if (d_hit) begin
						res_q   <= STAT_TRIPLE;
						state_q <= S_RESP;
					end else if (!issue) begin
						// last read already checked this cycle
						scan_idx_q <= '0;
						state_q    <= S_BSCAN;
					end
				end
				S_BSCAN: begin
					rvld_s1 <= issue;
					if (issue) begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
					if (b_hit) begin
						added_q <= added_q + 1'b1;
					end
					if (d_we) begin
						dwr_q <= dwr_q + 1'b1;
					end
					if (!issue) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (load_out) begin
						state_q <= S_IDLE;
						if (final_stat == STAT_ADMIT) begin
							bcount_q <= bcount_q + 1'b1;
							dcount_q <= dwr_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s_q <= s_in;
			e_q <= e_in;
		end
		if (load_out) begin
			status_q <= final_stat;
			ndr_q    <= (final_stat == STAT_ADMIT) ? NDR_W'(added_q) : '0;
		end
	end

	assign in_stall           = (state_q != S_IDLE);
	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign new_double_regions = ndr_q;

endmodule

FILE: rtl/idbt_checker.sv
`timescale 1ns / 1ps

module idbt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic [31:0]                interval_start,
	input logic [31:0]                interval_end,
	input logic                       out_valid,
	input logic                       out_stall,
	input idbt_pkg::status_t          status,
	input logic [idbt_pkg::NDR_W-1:0] new_double_regions
);

	import idbt_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(new_double_regions))
		else $error("stalled result changed");

	// only an admission reports new double regions
	a_ndr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_ADMIT) |-> new_double_regions == '0)
		else $error("refused transaction reports double regions");

	// one request in flight: input closes right after an accepted transaction
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction taken while busy");

	// a fresh result appears only from work in progress
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a transaction in progress");

	// an accepted invalid interval, with no result waiting, is refused as invalid
	a_invalid_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (interval_start >= interval_end) && !out_valid |=>
		##1 out_valid && (status == STAT_INVALID))
		else $error("invalid interval not refused");

endmodule

bind interval_double_booking_table idbt_checker u_idbt_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_stall           (in_stall),
	.interval_start     (interval_start),
	.interval_end       (interval_end),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.status             (status),
	.new_double_regions (new_double_regions)
);

FILE: test/interval_double_booking_table_tb.sv
`timescale 1ns / 1ps

module interval_double_booking_table_tb;

	import idbt_pkg::*;

	localparam int RANDOM_REQUESTS = 930;
	localparam int HOLD_CYCLES     = 3000;
	localparam int DRAIN_CYCLES    = 400;
	localparam int CYCLE_LIMIT     = 3000000;

	typedef struct packed {
		status_t          st;
		logic [NDR_W-1:0] nd;
	} verdict_t;

	typedef struct packed {
		time_t    lo;
		time_t    hi;
		logic     known;
		verdict_t want;
	} stim_row_t;

	// Rows marked known carry their verdict; the rest go through the predictor.
	localparam stim_row_t DIRECTED [20] = '{
		'{32'd7,          32'd7,          1'b1, '{STAT_INVALID, 7'd0}},
		'{32'hFFFF_FFFF,  32'd0,          1'b1, '{STAT_INVALID, 7'd0}},
		'{32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, '{STAT_INVALID, 7'd0}},
		'{32'd0,          32'd0,          1'b1, '{STAT_INVALID, 7'd0}},
		'{32'd0,          32'd100,        1'b1, '{STAT_ADMIT,   7'd0}},
		'{32'd50,         32'd150,        1'b1, '{STAT_ADMIT,   7'd1}},
		'{32'd99,         32'd100,        1'b1, '{STAT_TRIPLE,  7'd0}},
		'{32'd100,        32'd150,        1'b0, '{STAT_ADMIT,   7'd0}},
		'{32'd150,        32'd200,        1'b0, '{STAT_ADMIT,   7'd0}},
		'{32'd49,         32'd50,         1'b0, '{STAT_ADMIT,   7'd0}},
		'{32'hFFFF_FF00,  32'hFFFF_FFFF,  1'b0, '{STAT_ADMIT,   7'd0}},
		'{32'hFFFF_FFFE,  32'hFFFF_FFFF,  1'b0, '{STAT_ADMIT,   7'd0}},
		'{32'hFFFF_FFFE,  32'hFFFF_FFFF,  1'b0, '{STAT_ADMIT,   7'd0}},
		'{32'd2000,       32'd2010,       1'b0, '{STAT_ADMIT,   7'd0}},
		'{32'd2020,       32'd2030,       1'b0, '{STAT_ADMIT,   7'd0}},
		'{32'd2040,       32'd2050,       1'b0, '{STAT_ADMIT,   7'd0}},
		'{32'd2000,       32'd2050,       1'b0, '{STAT_ADMIT,   7'd0}},
		'{32'd2005,       32'd2006,       1'b0, '{STAT_ADMIT,   7'd0}},
		'{32'd0,          32'hFFFF_FFFF,  1'b0, '{STAT_ADMIT,   7'd0}},
		'{32'h7FFF_FFFF,  32'h8000_0000,  1'b0, '{STAT_ADMIT,   7'd0}}
	};

	localparam time_t CLUSTER_BASE [3] = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_F000};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	time_t            interval_start = '0;
	time_t            interval_end = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	status_t          status;
	logic [NDR_W-1:0] new_double_regions;

	interval_double_booking_table uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.interval_start     (interval_start),
		.interval_end       (interval_end),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.new_double_regions (new_double_regions)
	);

	// predicted reservation state
	time_t booked_lo [BOOKED_DEPTH];
	time_t booked_hi [BOOKED_DEPTH];
	int    booked_n = 0;
	time_t overlap_lo [DOUBLE_DEPTH];
	time_t overlap_hi [DOUBLE_DEPTH];
	int    overlap_n = 0;

	verdict_t verdicts_due [$];
	int       mismatches = 0;
	int       accepted_count = 0;
	int       cycle_count = 0;
	int       send_calm = 0;
	logic     calm_tail = 1'b0;
	int       hold_asked = 0;
	int       hold_served = 0;
	int       hold_ticks = 0;
	int       burst_ticks = 0;
	int       calm_ticks = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic verdict_t book_request(input time_t lo, input time_t hi);
		verdict_t v;
		int       i;
		int       hits;
		v.st = STAT_ADMIT;
		v.nd = '0;
		hits = 0;
		if (lo >= hi) begin
			v.st = STAT_INVALID;
			return v;
		end
		for (i = 0; i < overlap_n; i++) begin
			if (overlap_lo[i] < hi && lo < overlap_hi[i]) begin
				v.st = STAT_TRIPLE;
				return v;
			end
		end
		for (i = 0; i < booked_n; i++)
			if (booked_lo[i] < hi && lo < booked_hi[i])
				hits++;
		if (booked_n >= BOOKED_DEPTH || overlap_n + hits > DOUBLE_DEPTH) begin
			v.st = STAT_FULL;
			return v;
		end
		for (i = 0; i < booked_n; i++) begin
			if (booked_lo[i] < hi && lo < booked_hi[i]) begin
				overlap_lo[overlap_n] = (booked_lo[i] > lo) ? booked_lo[i] : lo;
				overlap_hi[overlap_n] = (booked_hi[i] < hi) ? booked_hi[i] : hi;
				overlap_n++;
			end
		end
		booked_lo[booked_n] = lo;
		booked_hi[booked_n] = hi;
		booked_n++;
		v.nd = NDR_W'(hits);
		return v;
	endfunction

	function automatic void pick_request(output time_t lo, output time_t hi);
		int    mode;
		int    k;
		time_t a;
		time_t b;
		time_t base;
		// hold back admissions so the booked table fills over the run, not at its start
		if (booked_n < BOOKED_DEPTH && booked_n > accepted_count / 8 + 4)
			mode = ($urandom_range(0, 1) == 0) ? 1 : 2;
		else
			mode = $urandom_range(0, 9);
		if (mode == 2 && overlap_n == 0)
			mode = 3;
		case (mode)
			0: begin
				lo = $urandom;
				hi = $urandom;
			end
			1: begin
				a = $urandom;
				b = $urandom;
				lo = (a > b) ? a : b;
				hi = (a > b) ? b : a;
			end
			2: begin
				// straddle the start of a known double region
				k = $urandom_range(0, overlap_n - 1);
				a = overlap_lo[k];
				lo = (a >= 20) ? a - $urandom_range(0, 19) : a;
				hi = (a < 32'hFFFF_FF00) ? a + 1 + $urandom_range(0, 50) : 32'hFFFF_FFFF;
			end
			default: begin
				base = CLUSTER_BASE[$urandom_range(0, 2)];
				lo = base + $urandom_range(0, 3000);
				if ($urandom_range(0, 3) == 0)
					hi = lo + $urandom_range(1, 600);
				else
					hi = lo + $urandom_range(1, 64);
				if (base == 32'hFFFF_F000 && $urandom_range(0, 7) == 0)
					hi = 32'hFFFF_FFFF;
			end
		endcase
	endfunction

	task automatic present_request(input time_t lo, input time_t hi, input logic known,
			input verdict_t want);
		verdict_t predicted;
		if (!calm_tail) begin
			if (send_calm > 0)
				send_calm--;
			else if ($urandom_range(0, 19) == 0)
				send_calm = $urandom_range(10, 60);
			else if ($urandom_range(0, 4) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		interval_start <= lo;
		interval_end <= hi;
		do @(posedge clk); while (in_stall);
		predicted = book_request(lo, hi);
		verdicts_due.push_back(known ? want : predicted);
		accepted_count++;
	endtask

	// receiver: random stall bursts, calm stretches, and one long hold-off on request
	always @(posedge clk) begin
		if (hold_ticks > 0) begin
			hold_ticks--;
			out_stall <= 1'b1;
		end else if (hold_served != hold_asked) begin
			hold_served++;
			hold_ticks = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (calm_tail) begin
			out_stall <= 1'b0;
		end else if (burst_ticks > 0) begin
			burst_ticks--;
			out_stall <= 1'b1;
		end else if (calm_ticks > 0) begin
			calm_ticks--;
			out_stall <= 1'b0;
		end else begin
			case ($urandom_range(0, 9))
				0: begin
					calm_ticks = $urandom_range(20, 200);
					out_stall <= 1'b0;
				end
				1, 2: begin
					burst_ticks = $urandom_range(0, 13);
					out_stall <= 1'b1;
				end
				default: out_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				$display("%0t: unexpected transaction, status %0d new_double_regions %0d",
					$time, status, new_double_regions);
				mismatches++;
			end else begin
				want = verdicts_due.pop_front();
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					mismatches++;
				end
				if (new_double_regions !== want.nd) begin
					$display("%0t: new_double_regions expected %0d actual %0d",
						$time, want.nd, new_double_regions);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		time_t lo;
		time_t hi;
		int    n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[r])
			present_request(DIRECTED[r].lo, DIRECTED[r].hi, DIRECTED[r].known, DIRECTED[r].want);
		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == 300)
				hold_asked <= hold_asked + 1;
			if (n == 600) begin
				// drain the block completely before going on
				in_valid <= 1'b0;
				do @(posedge clk); while (verdicts_due.size() != 0);
			end
			if (n == RANDOM_REQUESTS - 80)
				calm_tail <= 1'b1;
			pick_request(lo, hi);
			present_request(lo, hi, 1'b0, '0);
		end
		in_valid <= 1'b0;
		do @(posedge clk); while (verdicts_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
